// ----- sv/timed_delay_queue_with_suppression_macros.svh -----
// Assertion macros for the timed delay queue.
// Used by the top level only; no dependencies.
`ifndef TIMED_DELAY_QUEUE_WITH_SUPPRESSION_MACROS_SVH
`define TIMED_DELAY_QUEUE_WITH_SUPPRESSION_MACROS_SVH
`ifndef SYNTHESIS
`define TDQ_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define TDQ_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define TDQ_ASSERT_IMP(label, clk, rst, a, c)
`define TDQ_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ----- sv/tdq_pkg.sv -----
// Package for the timed delay queue: operation, status and state codes, entry, command, flag and action types.
// No dependencies.
`timescale 1ns / 1ps
package tdq_pkg;
   localparam int QueueDepthDefault = 16;
   localparam int TimeWidth = 48;
   localparam int HandleWidth = 16;

   typedef enum logic [2:0] {
      OP_INSERT  = 3'd0,
      OP_POP     = 3'd1,
      OP_DEC     = 3'd2,
      OP_RELEASE = 3'd3,
      OP_CANCEL  = 3'd4
   } op_type;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef enum logic [1:0] {S_IDLE, S_CMP, S_SHIFT, S_RESP} state_type;

   typedef struct packed {
      logic [47:0] send_time;
      logic        cls;
      logic [31:0] sid;
      logic [31:0] source;
      logic [31:0] nonce;
      logic [7:0]  counter;
      logic [15:0] handle;
      logic        has_packet;
   } entry_type;

   // Command broadcast to every cell in the shift state of an operation.
   typedef struct packed {
      logic      act;
      logic [2:0] op;
      entry_type key;
   } cmd_type;

   // Match flags a cell reports in the compare state.
   typedef struct packed {
      logic later;
      logic dec_hit;
      logic rel_hit;
      logic cancel_hit;
   } flags_type;

   // Per-cell action computed from the prefix chain.
   typedef struct packed {
      logic take_new;
      logic from_left;
      logic from_right;
      logic dec;
      logic rel;
   } act_type;
endpackage

// ----- sv/tdq_cell.sv -----
// One slot of the sorted queue: holds an entry and its valid bit, compares
// it with the request key and shifts it to or from its neighbors. Uses tdq_pkg.
`timescale 1ns / 1ps
module tdq_cell (
   input  logic                clock,
   input  logic                reset,
   input  tdq_pkg::cmd_type    cmd,
   input  tdq_pkg::act_type    act,
   input  tdq_pkg::entry_type  left_entry,
   input  logic                left_valid,
   input  tdq_pkg::entry_type  right_entry,
   input  logic                right_valid,
   output tdq_pkg::entry_type  entry,
   output logic                valid,
   output tdq_pkg::flags_type  flags
);
   import tdq_pkg::*;

   entry_type entry_ff, entry_in;
   logic valid_ff, valid_in;
   logic sid_eq;

   assign sid_eq = entry_ff.sid == cmd.key.sid;

   always_comb begin
      flags.later = valid_ff && (entry_ff.send_time >= cmd.key.send_time);
      flags.dec_hit = valid_ff && (entry_ff.cls == cmd.key.cls) && sid_eq &&
         (cmd.key.cls || (entry_ff.source == cmd.key.source &&
         entry_ff.nonce == cmd.key.nonce));
      flags.rel_hit = valid_ff && !entry_ff.cls && entry_ff.has_packet && sid_eq;
      flags.cancel_hit = valid_ff && !entry_ff.cls && sid_eq;
   end

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (act.take_new) begin
         entry_in = cmd.key;
         valid_in = 1'b1;
      end else if (act.from_left) begin
         entry_in = left_entry;
         valid_in = left_valid;
      end else if (act.from_right) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end
      if (act.dec && entry_ff.counter != 8'd0) begin
         entry_in.counter = entry_ff.counter - 8'd1;
      end
      if (act.rel) begin
         entry_in.has_packet = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;
endmodule

// ----- sv/timed_delay_queue_with_suppression.sv -----
// Timed delay queue with suppression: a row of QUEUE_DEPTH cells kept sorted
// by send time. Sequence: request accepted in the idle state, cells compare in
// the compare state, shift/update in the shift state, response valid in the
// response state. A new request is accepted only once the response has been
// taken and the block is idle again. A cancel repeats the compare and shift
// states for each entry it removes.
// Synchronous active-high reset empties the queue.
`timescale 1ns / 1ps
`include "timed_delay_queue_with_suppression_macros.svh"
module timed_delay_queue_with_suppression #(
   parameter int QUEUE_DEPTH = tdq_pkg::QueueDepthDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // kind[2:0], send_time[50:3], pkt_kind[51], key_sid[83:52],
   // key_source[115:84], key_nonce[147:116], forward_count[155:148],
   // packet_handle[171:156], zero fill up to 175
   input  logic [175:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], packet_valid[2], packet_dropped[3], out_handle[19:4],
   // head_valid[20], head_time[68:21], occupancy[73:69], zero fill to 79
   output logic [79:0]  rsp_tdata
);
   import tdq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   state_type state_ff, state_in;
   logic [2:0] op_ff;
   entry_type key_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0] status_ff, status_in;
   logic pv_ff, pv_in, pd_ff, pd_in;
   logic [15:0] oh_ff, oh_in;
   flags_type flags_ff [QUEUE_DEPTH];
   flags_type flags_w [QUEUE_DEPTH];
   act_type acts [QUEUE_DEPTH];
   entry_type ents [QUEUE_DEPTH];
   logic vals [QUEUE_DEPTH];
   cmd_type cmd;
   logic [QUEUE_DEPTH-1:0] later_v, dec_v, rel_v, can_v;
   logic [QUEUE_DEPTH-1:0] later_pre, dec_first, rel_first, can_pre;
   logic [QUEUE_DEPTH-1:0] ins_pos;
   logic again_in, again_ff;
   logic full;

   assign full = count_ff == CW'(QUEUE_DEPTH);
   assign cmd.act = state_ff == S_SHIFT;
   assign cmd.op = op_ff;
   assign cmd.key = key_ff;

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         entry_type le, re;
         logic lv, rv;
         if (g == 0) begin : g_l0
            assign le = key_ff;
            assign lv = 1'b0;
         end else begin : g_l
            assign le = ents[g-1];
            assign lv = vals[g-1];
         end
         if (g == QUEUE_DEPTH - 1) begin : g_rn
            assign re = key_ff;
            assign rv = 1'b0;
         end else begin : g_r
            assign re = ents[g+1];
            assign rv = vals[g+1];
         end
         tdq_cell u_cell (
            .clock(clock), .reset(reset), .cmd(cmd), .act(acts[g]),
            .left_entry(le), .left_valid(lv), .right_entry(re), .right_valid(rv),
            .entry(ents[g]), .valid(vals[g]), .flags(flags_w[g])
         );
         assign later_v[g] = flags_ff[g].later;
         assign dec_v[g] = flags_ff[g].dec_hit;
         assign rel_v[g] = flags_ff[g].rel_hit;
         assign can_v[g] = flags_ff[g].cancel_hit;
         // Prefix: any hit at or before this slot; decrement and release take the first hit only.
         if (g == 0) begin : g_p0
            assign later_pre[g] = later_v[g];
            assign can_pre[g] = can_v[g];
            assign dec_first[g] = dec_v[g];
            assign rel_first[g] = rel_v[g];
            assign ins_pos[g] = later_v[g] || (count_ff == CW'(0));
         end else begin : g_p
            assign later_pre[g] = later_pre[g-1] | later_v[g];
            assign can_pre[g] = can_pre[g-1] | can_v[g];
            assign dec_first[g] = dec_v[g] && !(|dec_v[g-1:0]);
            assign rel_first[g] = rel_v[g] && !(|rel_v[g-1:0]);
            assign ins_pos[g] = (later_v[g] && !later_pre[g-1]) ||
               (!later_pre[g-1] && !later_v[g] && count_ff == CW'(g));
         end
         always_comb begin
            acts[g] = '0;
            if (cmd.act) begin
               case (op_ff)
                  OP_INSERT: begin
                     if (!full) begin
                        acts[g].take_new = ins_pos[g];
                        acts[g].from_left = (g != 0) && later_pre[g] && !ins_pos[g];
                     end
                  end
                  OP_POP: acts[g].from_right = count_ff != CW'(0);
                  OP_DEC: acts[g].dec = dec_first[g];
                  OP_RELEASE: acts[g].rel = rel_first[g];
                  OP_CANCEL: acts[g].from_right = can_pre[g];
                  default: acts[g] = '0;
               endcase
            end
         end
         always_ff @(posedge clock) begin
            flags_ff[g] <= flags_w[g];
         end
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_CMP;
         S_CMP: state_in = S_SHIFT;
         S_SHIFT: state_in = again_in ? S_CMP : S_RESP;
         S_RESP: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      status_in = status_ff;
      pv_in = pv_ff;
      pd_in = pd_ff;
      oh_in = oh_ff;
      again_in = 1'b0;
      if (state_ff == S_IDLE) begin
         status_in = ST_OK;
         pv_in = 1'b0;
         pd_in = 1'b0;
         oh_in = '0;
      end
      if (state_ff == S_SHIFT) begin
         case (op_ff)
            OP_INSERT: begin
               if (full) status_in = ST_FULL;
               else count_in = count_ff + CW'(1);
            end
            OP_POP: begin
               if (count_ff == CW'(0)) begin
                  status_in = ST_EMPTY;
               end else begin
                  count_in = count_ff - CW'(1);
                  if (ents[0].has_packet) begin
                     oh_in = ents[0].handle;
                     pd_in = ents[0].counter == 8'd0;
                     pv_in = ents[0].counter != 8'd0;
                  end
               end
            end
            OP_DEC: if (!(|dec_v)) status_in = ST_NOT_FOUND;
            OP_RELEASE: if (!(|rel_v)) status_in = ST_NOT_FOUND;
            OP_CANCEL: begin
               if (|can_v) begin
                  count_in = count_ff - CW'(1);
                  again_in = 1'b1;
               end else if (!again_ff) begin
                  status_in = ST_NOT_FOUND;
               end
            end
            default: status_in = ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         op_ff <= req_tdata[2:0];
         key_ff.send_time <= req_tdata[50:3];
         key_ff.cls <= req_tdata[51];
         key_ff.sid <= req_tdata[83:52];
         key_ff.source <= req_tdata[115:84];
         key_ff.nonce <= req_tdata[147:116];
         key_ff.counter <= req_tdata[155:148];
         key_ff.handle <= req_tdata[171:156];
         key_ff.has_packet <= 1'b1;
      end
      status_ff <= status_in;
      pv_ff <= pv_in;
      pd_ff <= pd_in;
      oh_ff <= oh_in;
      if (state_ff == S_IDLE) again_ff <= 1'b0;
      else if (state_ff == S_SHIFT) again_ff <= again_ff | again_in;
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      req_tready = state_ff == S_IDLE;
      rsp_tvalid = state_ff == S_RESP;
      rsp_tdata = '0;
      rsp_tdata[1:0] = status_ff;
      rsp_tdata[2] = pv_ff;
      rsp_tdata[3] = pd_ff;
      rsp_tdata[19:4] = oh_ff;
      rsp_tdata[20] = vals[0];
      rsp_tdata[68:21] = vals[0] ? ents[0].send_time : 48'd0;
      rsp_tdata[73:69] = 5'(count_ff);
   end

   `TDQ_ASSERT_IMP(a_head_count, clock, reset, 1'b1, vals[0] == (count_ff != CW'(0)))
   `TDQ_ASSERT_IMP(a_count_max, clock, reset, 1'b1, count_ff <= CW'(QUEUE_DEPTH))
   `TDQ_ASSERT_NXT(a_resp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(count_ff))
endmodule

// ----- sim/tdq_checker.sv -----
// Checker for the timed delay queue: watches both streams, keeps its own copy
// of the sorted queue and compares each response with the predicted one.
// Depends on tdq_pkg.
`timescale 1ns / 1ps
module tdq_checker #(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [175:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [79:0]  rsp_tdata,
   output int           fail_count,
   output int           pending
);
   import tdq_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic        packet_valid;
      logic        packet_dropped;
      logic [15:0] out_handle;
      logic        head_valid;
      logic [47:0] head_time;
      logic [4:0]  occupancy;
   } result_type;

   entry_type slots[DEPTH];
   int fill;
   result_type expected_results[$];

   assign pending = expected_results.size();

   function automatic void drop_slot(int pos);
      for (int i = pos; i + 1 < fill; i++) slots[i] = slots[i + 1];
      fill--;
   endfunction

   function automatic result_type apply_request(logic [175:0] d);
      result_type r;
      logic [2:0] op;
      entry_type k;
      int pos;
      int i;
      r = '0;
      op = d[2:0];
      k.send_time = d[50:3];
      k.cls = d[51];
      k.sid = d[83:52];
      k.source = d[115:84];
      k.nonce = d[147:116];
      k.counter = d[155:148];
      k.handle = d[171:156];
      k.has_packet = 1'b1;
      r.status = ST_OK;
      case (op)
         OP_INSERT: begin
            if (fill >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               pos = fill;
               for (i = 0; i < fill; i++) begin
                  if (slots[i].send_time >= k.send_time) begin
                     pos = i;
                     break;
                  end
               end
               for (i = fill; i > pos; i--) slots[i] = slots[i - 1];
               slots[pos] = k;
               fill++;
            end
         end
         OP_POP: begin
            if (fill == 0) begin
               r.status = ST_EMPTY;
            end else begin
               if (slots[0].has_packet) begin
                  r.out_handle = slots[0].handle;
                  if (slots[0].counter < 1) r.packet_dropped = 1'b1;
                  else r.packet_valid = 1'b1;
               end
               drop_slot(0);
            end
         end
         OP_DEC: begin
            r.status = ST_NOT_FOUND;
            for (i = 0; i < fill; i++) begin
               if (slots[i].cls == k.cls && slots[i].sid == k.sid &&
                   (k.cls || (slots[i].source == k.source &&
                              slots[i].nonce == k.nonce))) begin
                  if (slots[i].counter > 0) slots[i].counter--;
                  r.status = ST_OK;
                  break;
               end
            end
         end
         OP_RELEASE: begin
            r.status = ST_NOT_FOUND;
            for (i = 0; i < fill; i++) begin
               if (!slots[i].cls && slots[i].has_packet && slots[i].sid == k.sid) begin
                  slots[i].has_packet = 1'b0;
                  r.status = ST_OK;
                  break;
               end
            end
         end
         OP_CANCEL: begin
            r.status = ST_NOT_FOUND;
            i = 0;
            while (i < fill) begin
               if (!slots[i].cls && slots[i].sid == k.sid) begin
                  drop_slot(i);
                  r.status = ST_OK;
               end else begin
                  i++;
               end
            end
         end
         default: ;
      endcase
      r.head_valid = fill > 0;
      r.head_time = fill > 0 ? slots[0].send_time : '0;
      r.occupancy = fill[4:0];
      return r;
   endfunction

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         fill = 0;
         fail_count = 0;
         expected_results.delete();
      end else begin
         if (req_tvalid && req_tready) expected_results.push_back(apply_request(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[1:0];
            got.packet_valid = rsp_tdata[2];
            got.packet_dropped = rsp_tdata[3];
            got.out_handle = rsp_tdata[19:4];
            got.head_valid = rsp_tdata[20];
            got.head_time = rsp_tdata[68:21];
            got.occupancy = rsp_tdata[73:69];
            if (expected_results.size() == 0) begin
               $error("unexpected response %0h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("status", 64'(want.status), 64'(got.status));
               compare_field("packet_valid", 64'(want.packet_valid),
                  64'(got.packet_valid));
               compare_field("packet_dropped", 64'(want.packet_dropped),
                  64'(got.packet_dropped));
               compare_field("out_handle", 64'(want.out_handle), 64'(got.out_handle));
               compare_field("head_valid", 64'(want.head_valid), 64'(got.head_valid));
               compare_field("head_time", 64'(want.head_time), 64'(got.head_time));
               compare_field("occupancy", 64'(want.occupancy), 64'(got.occupancy));
            end
         end
      end
   end
endmodule

// ----- sim/tb_timed_delay_queue_with_suppression.sv -----
// Testbench top for the timed delay queue: drives directed and random requests
// with random gaps and stalls, and reports the verdict from tdq_checker.
// Depends on tdq_pkg, tdq_checker and the block.
`timescale 1ns / 1ps
module tb_timed_delay_queue_with_suppression;
   import tdq_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [175:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [79:0]  rsp_tdata;
   int           fail_count;
   int           pending;
   int           cycle_count;
   logic         sending_done;

   // Small pools of keys make matches, releases and cancels hit often.
   logic [31:0] sid_pool[4];
   logic [31:0] source_pool[4];
   logic [31:0] nonce_pool[4];

   timed_delay_queue_with_suppression dut (.*);

   tdq_checker #(.DEPTH(16)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 200000) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         gap = $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   function automatic logic [175:0] pack_request(logic [2:0] op, logic [47:0] t,
         logic cls, logic [31:0] sid, logic [31:0] src, logic [31:0] nonce,
         logic [7:0] cnt, logic [15:0] hdl);
      return {4'b0, hdl, cnt, nonce, src, sid, cls, t, op};
   endfunction

   task automatic send_request(logic [175:0] d, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random(int gap);
      logic [2:0] op;
      logic [47:0] t;
      logic cls;
      int s;
      int p;
      p = $urandom_range(0, 99);
      op = p < 40 ? OP_INSERT : p < 65 ? OP_POP : p < 80 ? OP_DEC :
           p < 90 ? OP_RELEASE : p < 98 ? OP_CANCEL : 3'($urandom_range(5, 7));
      s = $urandom_range(0, 3);
      t = $urandom_range(0, 3) == 0 ? 48'({$urandom, $urandom}) :
          48'($urandom_range(0, 40));
      cls = 1'($urandom_range(0, 1));
      send_request(pack_request(op, t, cls,
         $urandom_range(0, 9) == 0 ? $urandom : sid_pool[s],
         $urandom_range(0, 9) == 0 ? $urandom : source_pool[s],
         $urandom_range(0, 9) == 0 ? $urandom : nonce_pool[s],
         $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 1)) : 8'($urandom),
         16'($urandom)), gap);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      sending_done = 1'b0;
      for (int i = 0; i < 4; i++) begin
         sid_pool[i] = $urandom;
         source_pool[i] = $urandom;
         nonce_pool[i] = $urandom;
      end
      sid_pool[0] = '1;
      source_pool[0] = '1;
      nonce_pool[0] = '1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_request(pack_request(OP_POP, '0, 0, '0, '0, '0, '0, '0), 0);
      send_request(pack_request(OP_DEC, '0, 1, '1, '0, '0, '0, '0), 0);
      send_request(pack_request(OP_RELEASE, '0, 0, '1, '0, '0, '0, '0), 0);
      send_request(pack_request(OP_CANCEL, '0, 0, '1, '0, '0, '0, '0), 0);
      for (int i = 0; i < 17; i++)
         send_request(pack_request(OP_INSERT, i == 0 ? '1 : 48'(i % 3), i[0],
            i < 8 ? '1 : '0, '1, '1, i == 1 ? 8'd0 : '1, 16'(i * 4099)), 0);
      send_request(pack_request(OP_DEC, '0, 0, '1, '1, '1, '0, '0), 0);
      send_request(pack_request(OP_RELEASE, '0, 0, '1, '0, '0, '0, '0), 0);
      send_request(pack_request(3'd7, '1, 1, '1, '1, '1, '1, '1), 0);
      send_request(pack_request(OP_CANCEL, '0, 0, '1, '0, '0, '0, '0), 0);
      for (int i = 0; i < 600; i++) begin
         if (i == 300) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         send_random($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 9));
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      sending_done = 1'b1;
   end

   initial begin
      @(posedge sending_done);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
